// ===== rtl/twg_pkg.sv =====
// Shared constants, codes, control structs and sine table builder for the waveform generator
`default_nettype none

package twg_pkg;

   localparam int PERIOD_BITS     = 24;
   localparam int SINE_TABLE_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int WAVE_BITS       = 3;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int PERIOD_RESET    = 10000;

   // divider produces one quotient bit per step, the quotient never exceeds 16 bits
   localparam int DIV_STEPS    = SAMPLE_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [30:0]            ONE_Q30        = 31'h4000_0000;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID     = 16'h8000;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL    = 16'hFFFF;
   localparam logic [63:0]            HALF_PI_Q30    = 64'd1686629713;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVEFORM       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD_TICKS   = 2'd2;

   // waveform codes
   localparam logic [WAVE_BITS-1:0] WAVE_CONSTANT = 3'd0;
   localparam logic [WAVE_BITS-1:0] WAVE_SAWTOOTH = 3'd1;
   localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
   localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd3;
   localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd4;

   typedef enum logic [2:0] {
      PH_WAIT_HIGH = 3'b001,
      PH_PLAY      = 3'b010,
      PH_WAIT_LOW  = 3'b100
   } phase_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SRC   = 7'b0000010,
      ST_NUM   = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_TAB   = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic start;          // latch elapsed/period for a new request
      logic clear_elapsed;  // period restarts at zero
      logic src;            // last flag, divider source (e or triangle span)
      logic num;            // build dividend, load divider
      logic div_step;       // one quotient bit
      logic tab;            // quarter-wave table read
      logic scale;          // select and scale the sample
      logic out_load;       // load result register, advance elapsed
   } cmd_type;

   typedef struct packed {
      logic last;
      logic div_last;
      logic out_free;
   } sts_type;

   // Q30 sine of m/(2^(tbits-2)) * pi/2, truncated Taylor series through x^17.
   // Only evaluated at elaboration to build the constant table.
   function automatic logic [30:0] sine_q30(input int unsigned m, input int unsigned tbits);
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      longint       sum;
      int unsigned  quarter;
      quarter = 1 << (tbits - 2);
      if (m == 0) begin
         return 31'd0;
      end
      if (m >= quarter) begin
         return ONE_Q30;
      end
      x   = (64'(m) * HALF_PI_Q30) >> (tbits - 2);
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      for (int unsigned n = 1; n <= 8; n++) begin
         t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n[0]) begin
            sum = sum - longint'(t);
         end else begin
            sum = sum + longint'(t);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
         sum = longint'(ONE_Q30);
      end
      return 31'(sum);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/twg_if.sv =====
// Request and response channel interfaces of the waveform generator
`default_nettype none

interface twg_req_if;
   logic valid;
   logic ready;
   logic trigger_level;

   modport source (output valid, output trigger_level, input ready);
   modport sink   (input valid, input trigger_level, output ready);
endinterface

interface twg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [twg_pkg::SAMPLE_BITS-1:0]    sample;
   logic                               period_last;

   modport source (output valid, output sample, output period_last, input ready);
   modport sink   (input valid, input sample, input period_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/twg_ctrl.sv =====
// Controller: trigger phase tracking and the per-request step sequencer
`default_nettype none

module twg_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              trigger_level,
   input  wire logic              trigger_enable,
   input  wire twg_pkg::sts_type  sts,
   output logic                   req_ready,
   output twg_pkg::cmd_type       cmd
);

   twg_pkg::state_type state_ff, state_in;
   twg_pkg::phase_type phase_ff, phase_in;
   logic               accept;

   assign req_ready = (state_ff == twg_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      case (state_ff)
         twg_pkg::ST_IDLE: begin
            if (accept) begin
               if (!trigger_enable) begin
                  cmd.start         = 1'b1;
                  cmd.clear_elapsed = (phase_ff != twg_pkg::PH_PLAY);
                  phase_in          = twg_pkg::PH_PLAY;
               end else if (phase_ff == twg_pkg::PH_WAIT_LOW) begin
                  if (!trigger_level) begin
                     phase_in = twg_pkg::PH_WAIT_HIGH;
                  end
               end else if (phase_ff != twg_pkg::PH_PLAY) begin
                  if (trigger_level) begin
                     cmd.start         = 1'b1;
                     cmd.clear_elapsed = 1'b1;
                     phase_in          = twg_pkg::PH_PLAY;
                  end
               end else begin
                  cmd.start = 1'b1;
               end
               if (cmd.start) begin
                  state_in = twg_pkg::ST_SRC;
               end
            end
         end
         twg_pkg::ST_SRC: begin
            cmd.src  = 1'b1;
            state_in = twg_pkg::ST_NUM;
         end
         twg_pkg::ST_NUM: begin
            cmd.num  = 1'b1;
            state_in = twg_pkg::ST_DIV;
         end
         twg_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = twg_pkg::ST_TAB;
            end
         end
         twg_pkg::ST_TAB: begin
            cmd.tab  = 1'b1;
            state_in = twg_pkg::ST_SCALE;
         end
         twg_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = twg_pkg::ST_OUT;
         end
         twg_pkg::ST_OUT: begin
            // hold until the result register can take the sample
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = twg_pkg::ST_IDLE;
               if (sts.last && trigger_enable) begin
                  phase_in = twg_pkg::PH_WAIT_LOW;
               end
            end
         end
         default: begin
            state_in = twg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twg_pkg::ST_IDLE;
         phase_ff <= twg_pkg::PH_WAIT_HIGH;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/twg_dp.sv =====
// Datapath: elapsed counter, bit-serial divider, sine table and result register
`default_nettype none

module twg_dp #(
   parameter int PERIOD_BITS     = twg_pkg::PERIOD_BITS,
   parameter int SINE_TABLE_BITS = twg_pkg::SINE_TABLE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire twg_pkg::cmd_type                    cmd,
   input  wire logic [twg_pkg::WAVE_BITS-1:0]       waveform,
   input  wire logic [PERIOD_BITS-1:0]              period_ticks,
   input  wire logic                                rsp_ready,
   output twg_pkg::sts_type                         sts,
   output logic                                     rsp_valid,
   output logic [twg_pkg::SAMPLE_BITS-1:0]          rsp_sample,
   output logic                                     rsp_period_last
);

   localparam int SB      = twg_pkg::SAMPLE_BITS;
   localparam int NW      = PERIOD_BITS + SB;
   localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
   localparam logic [SINE_TABLE_BITS-2:0] QUARTER_IDX = {1'b1, {(SINE_TABLE_BITS-2){1'b0}}};

   typedef logic [30:0] qtab_type [QUARTER+1];

   function automatic qtab_type build_qtab();
      qtab_type tab;
      for (int i = 0; i <= QUARTER; i++) begin
         tab[i] = twg_pkg::sine_q30(i, SINE_TABLE_BITS);
      end
      return tab;
   endfunction

   // quarter-wave sine in Q30, the other quadrants come from symmetry
   localparam qtab_type QTAB = build_qtab();

   logic [PERIOD_BITS-1:0]          elapsed_ff, e_ff, p_ff, x_ff, rem_ff;
   logic [twg_pkg::WAVE_BITS-1:0]   wave_ff;
   logic                            last_ff, neg_ff;
   logic [SB-1:0]                   quo_ff, sample_ff;
   logic [twg_pkg::DIV_CNT_BITS-1:0] cnt_ff;
   logic [30:0]                     sine_ff;
   logic                            rsp_valid_ff, rsp_last_ff;
   logic [SB-1:0]                   rsp_sample_ff;

   logic [PERIOD_BITS-1:0] p_eff, e0;
   logic [PERIOD_BITS:0]   two_e, tri_span;
   logic [NW-1:0]          numer;
   logic [PERIOD_BITS:0]   trial, diff;
   logic                   ge;
   logic [SINE_TABLE_BITS-1:0] kidx;
   logic [SINE_TABLE_BITS-2:0] midx, ridx;
   logic [31:0]            snum;
   logic [47:0]            sprod;
   logic [SB-1:0]          sample_sel;

   assign p_eff = (period_ticks == '0) ? PERIOD_BITS'(1) : period_ticks;
   assign e0    = cmd.clear_elapsed ? '0 : elapsed_ff;

   assign two_e    = {e_ff, 1'b0};
   assign tri_span = (two_e >= {1'b0, p_ff}) ? (two_e - {1'b0, p_ff})
                                             : ({1'b0, p_ff} - two_e);

   // sine wants e*N, the others x*65535
   assign numer = (wave_ff == twg_pkg::WAVE_SINE) ? NW'({x_ff, {SINE_TABLE_BITS{1'b0}}})
                                                  : ({x_ff, {SB{1'b0}}} - NW'(x_ff));

   assign trial = {rem_ff, quo_ff[SB-1]};
   assign diff  = trial - {1'b0, p_ff};
   assign ge    = (trial >= {1'b0, p_ff});

   assign kidx = quo_ff[SINE_TABLE_BITS-1:0];
   assign ridx = {1'b0, kidx[SINE_TABLE_BITS-3:0]};
   assign midx = kidx[SINE_TABLE_BITS-2] ? (QUARTER_IDX - ridx) : ridx;

   assign snum  = neg_ff ? ({1'b0, twg_pkg::ONE_Q30} - {1'b0, sine_ff})
                         : ({1'b0, twg_pkg::ONE_Q30} + {1'b0, sine_ff});
   assign sprod = {snum, 16'h0000} - {16'h0000, snum};

   always_comb begin
      case (wave_ff)
         twg_pkg::WAVE_CONSTANT: sample_sel = twg_pkg::SAMPLE_MID;
         twg_pkg::WAVE_SAWTOOTH: sample_sel = quo_ff;
         twg_pkg::WAVE_SQUARE:   sample_sel = (two_e < {1'b0, p_ff}) ? twg_pkg::SAMPLE_FULL
                                                                     : '0;
         twg_pkg::WAVE_SINE:     sample_sel = sprod[46:31];
         twg_pkg::WAVE_TRIANGLE: sample_sel = quo_ff;
         default:                sample_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         p_ff    <= p_eff;
         e_ff    <= (e0 >= p_eff) ? (p_eff - PERIOD_BITS'(1)) : e0;
         wave_ff <= waveform;
      end
      if (cmd.src) begin
         last_ff <= (e_ff == (p_ff - PERIOD_BITS'(1)));
         x_ff    <= (wave_ff == twg_pkg::WAVE_TRIANGLE) ? tri_span[PERIOD_BITS-1:0] : e_ff;
      end
      if (cmd.num) begin
         // upper dividend bits are already below the divisor
         rem_ff <= numer[NW-1:SB];
         quo_ff <= numer[SB-1:0];
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
         quo_ff <= {quo_ff[SB-2:0], ge};
         cnt_ff <= cnt_ff + twg_pkg::DIV_CNT_BITS'(1);
      end
      if (cmd.tab) begin
         sine_ff <= QTAB[midx];
         neg_ff  <= kidx[SINE_TABLE_BITS-1];
      end
      if (cmd.scale) begin
         sample_ff <= sample_sel;
      end
      if (cmd.out_load) begin
         rsp_sample_ff <= sample_ff;
         rsp_last_ff   <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            elapsed_ff   <= last_ff ? '0 : (e_ff + PERIOD_BITS'(1));
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.last     = last_ff;
   assign sts.div_last = (cnt_ff == twg_pkg::DIV_CNT_BITS'(twg_pkg::DIV_STEPS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_period_last = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/triggered_waveform_generator.sv =====
// Top level: configuration registers, controller and datapath of the waveform generator
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   trigger_level (one timer tick)
//   rsp_ch   out  valid/ready   sample[15:0], period_last
//   csr_*    in   csr_wr_en     csr_index[1:0], csr_wr_data[PERIOD_BITS-1:0]
//
// A sample request runs the source, dividend, 16-step bit-serial divider, table, scale
// and output steps; the next request is taken once the sample is loaded. A request with
// no sample (trigger wait) leaves the controller idle. Reset is synchronous and needs no
// clearing pass. A stalled response holds in the result register while the next request runs.
`default_nettype none

module triggered_waveform_generator #(
   parameter int PERIOD_BITS     = twg_pkg::PERIOD_BITS,
   parameter int SINE_TABLE_BITS = twg_pkg::SINE_TABLE_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   twg_req_if.sink                                    req_ch,
   twg_rsp_if.source                                  rsp_ch,
   input  wire logic                                  csr_wr_en,
   input  wire logic [twg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [PERIOD_BITS-1:0]                csr_wr_data
);

   logic [twg_pkg::WAVE_BITS-1:0] waveform_ff;
   logic                          trigger_enable_ff;
   logic [PERIOD_BITS-1:0]        period_ticks_ff;

   twg_pkg::cmd_type cmd;
   twg_pkg::sts_type sts;
   logic             req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff       <= twg_pkg::WAVE_TRIANGLE;
         trigger_enable_ff <= 1'b0;
         period_ticks_ff   <= PERIOD_BITS'(twg_pkg::PERIOD_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            twg_pkg::CSR_WAVEFORM:       waveform_ff       <= csr_wr_data[twg_pkg::WAVE_BITS-1:0];
            twg_pkg::CSR_TRIGGER_ENABLE: trigger_enable_ff <= csr_wr_data[0];
            twg_pkg::CSR_PERIOD_TICKS:   period_ticks_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   twg_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .trigger_level  (req_ch.trigger_level),
      .trigger_enable (trigger_enable_ff),
      .sts            (sts),
      .req_ready      (req_ready),
      .cmd            (cmd)
   );

   twg_dp #(
      .PERIOD_BITS     (PERIOD_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .waveform        (waveform_ff),
      .period_ticks    (period_ticks_ff),
      .rsp_ready       (rsp_ch.ready),
      .sts             (sts),
      .rsp_valid       (rsp_ch.valid),
      .rsp_sample      (rsp_ch.sample),
      .rsp_period_last (rsp_ch.period_last)
   );

   assign req_ch.ready = req_ready;

`ifndef SYNTHESIS
   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (req_ch.valid && req_ch.ready))
      else $error("period step started without an accepted request");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.src, cmd.num, cmd.div_step, cmd.tab, cmd.scale,
                cmd.out_load}))
      else $error("controller issued more than one step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result register overwritten while a response is pending");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_ch.valid)
      else $error("loaded sample not presented on the response channel");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/twg_sample_checker.sv =====
// Watches the request, response and register ports, predicts every sample and compares
module twg_sample_checker import twg_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   twg_req_if                             req_mon,
   twg_rsp_if                             rsp_mon,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [PERIOD_BITS-1:0]    csr_wr_data,
   input  wire logic                      drain_check,
   output int                             fail_count,
   output int                             samples_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned     SINE_N          = 1 << SINE_TABLE_BITS;
   localparam int unsigned     SINE_QUARTER    = SINE_N / 4;
   localparam longint unsigned Q30             = 64'd1 << 30;
   localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   period_last;
   } sample_item_t;

   logic [SAMPLE_BITS-1:0] sine_rom [SINE_N];
   sample_item_t           expected_samples [$];

   logic [WAVE_BITS-1:0]   waveform_reg;
   logic                   trig_mode_reg;
   logic [PERIOD_BITS-1:0] period_reg;
   phase_type              phase_now;
   logic [PERIOD_BITS-1:0] elapsed_now;
   bit                     drain_done;

   // Q30 sine of m quarter-steps of pi/2, truncated Taylor series through x^17
   function automatic longint unsigned sine_fraction(input int unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint          acc;
      if (m == 0) begin
         return 0;
      end
      if (m >= SINE_QUARTER) begin
         return Q30;
      end
      x   = (longint'(m) * RIGHT_ANGLE_Q30) >> (SINE_TABLE_BITS - 2);
      x2  = (x * x) >> 30;
      t   = x;
      acc = longint'(x);
      for (int unsigned n = 1; n <= 8; n++) begin
         t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(t);
         end else begin
            acc = acc + longint'(t);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > longint'(Q30)) begin
         acc = longint'(Q30);
      end
      return longint'(acc);
   endfunction

   initial begin
      int unsigned     q;
      int unsigned     r;
      longint unsigned s;
      longint unsigned num;
      for (int unsigned k = 0; k < SINE_N; k++) begin
         q   = k / SINE_QUARTER;
         r   = k % SINE_QUARTER;
         s   = sine_fraction((q % 2 == 1) ? SINE_QUARTER - r : r);
         num = (q >= 2) ? Q30 - s : Q30 + s;
         sine_rom[k] = SAMPLE_BITS'((num * 65535) >> 31);
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] waveform_value(input logic [WAVE_BITS-1:0] code,
                                                             input longint unsigned e,
                                                             input longint unsigned p);
      longint unsigned d;
      case (code)
         WAVE_CONSTANT: return SAMPLE_MID;
         WAVE_SAWTOOTH: return SAMPLE_BITS'((e * 65535) / p);
         WAVE_SQUARE:   return (2 * e < p) ? SAMPLE_FULL : '0;
         WAVE_SINE:     return sine_rom[((e << SINE_TABLE_BITS) / p) % SINE_N];
         WAVE_TRIANGLE: begin
            d = (2 * e >= p) ? 2 * e - p : p - 2 * e;
            return SAMPLE_BITS'((d * 65535) / p);
         end
         default:       return '0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      fail_count++;
   endtask

   // one timer tick: advance the phase machine, queue a sample if one is played
   task automatic predict_tick(input logic level);
      longint unsigned p;
      longint unsigned e;
      logic            last;
      sample_item_t    want;
      p = (period_reg == '0) ? 1 : longint'(period_reg);
      if (!trig_mode_reg) begin
         if (phase_now != PH_PLAY) begin
            phase_now   = PH_PLAY;
            elapsed_now = '0;
         end
      end else if (phase_now == PH_WAIT_LOW) begin
         if (!level) begin
            phase_now = PH_WAIT_HIGH;
         end
         return;
      end else if (phase_now != PH_PLAY) begin
         if (!level) begin
            phase_now = PH_WAIT_HIGH;
            return;
         end
         phase_now   = PH_PLAY;
         elapsed_now = '0;
      end
      e = longint'(elapsed_now);
      // period shortened while playing: clamp onto the last tick
      if (e >= p) begin
         e = p - 1;
      end
      last             = (e + 1 >= p);
      want.sample      = waveform_value(waveform_reg, e, p);
      want.period_last = last;
      expected_samples.push_back(want);
      if (last) begin
         elapsed_now = '0;
         if (trig_mode_reg) begin
            phase_now = PH_WAIT_LOW;
         end
      end else begin
         elapsed_now = PERIOD_BITS'(e + 1);
      end
   endtask

   always @(posedge clock) begin
      sample_item_t want;
      if (reset) begin
         expected_samples.delete();
         waveform_reg      = WAVE_TRIANGLE;
         trig_mode_reg     = 1'b0;
         period_reg        = PERIOD_BITS'(PERIOD_RESET);
         phase_now         = PH_WAIT_HIGH;
         elapsed_now       = '0;
         fail_count        = 0;
         drain_done        = 1'b0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("unexpected sample %h last %b",
                                         rsp_mon.sample, rsp_mon.period_last));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_mon.sample !== want.sample) begin
                  report_mismatch($sformatf("sample %h, expected %h",
                                            rsp_mon.sample, want.sample));
               end
               if (rsp_mon.period_last !== want.period_last) begin
                  report_mismatch($sformatf("period_last %b, expected %b (sample %h)",
                                            rsp_mon.period_last, want.period_last,
                                            want.sample));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_tick(req_mon.trigger_level);
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WAVEFORM:       waveform_reg  = csr_wr_data[WAVE_BITS-1:0];
               CSR_TRIGGER_ENABLE: trig_mode_reg = csr_wr_data[0];
               CSR_PERIOD_TICKS:   period_reg    = csr_wr_data;
               default: ;
            endcase
         end
         if (drain_check && !drain_done) begin
            drain_done = 1'b1;
            if (expected_samples.size() != 0) begin
               report_mismatch($sformatf("%0d expected samples never arrived",
                                         expected_samples.size()));
            end
         end
      end
      samples_pending = expected_samples.size();
   end

endmodule

// ===== tb/sv/tb_triggered_waveform_generator.sv =====
// Top of the waveform generator testbench: clock, reset, tick stimulus, register writes, verdict
module tb_triggered_waveform_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import twg_pkg::*;

   localparam int                        RESET_CYCLES   = 7;
   localparam int                        IDLE_CYCLES    = 30;
   localparam int                        HOLD_CYCLES    = 400;
   localparam int                        RANDOM_TICKS   = 500;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED     = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [PERIOD_BITS-1:0]    csr_wr_data;
   logic                      drain_check;
   int                        fail_count;
   int                        samples_pending;

   bit hold_request;
   bit gaps_on;
   int burst_left;
   int ticks_sent;

   twg_req_if req_ch();
   twg_rsp_if rsp_ch();

   triggered_waveform_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   twg_sample_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .drain_check       (drain_check),
      .fail_count        (fail_count),
      .samples_pending   (samples_pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: stall segments of random style, one long hold-off on request
   initial begin
      int  mode;
      int  seg_left;
      bit  hold_done;
      rsp_ch.ready = 1'b0;
      seg_left     = 0;
      mode         = 0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(3);
               seg_left = $urandom_range(8, 80);
            end
            seg_left--;
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(1));
               2:       rsp_ch.ready <= ($urandom_range(7) != 0);
               default: rsp_ch.ready <= ($urandom_range(3) == 0);
            endcase
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_tick(input logic level);
      int gap;
      req_ch.valid         <= 1'b1;
      req_ch.trigger_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      ticks_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(7);
         gap = 0;
         if (gaps_on) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 30) : $urandom_range(3);
         end
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (samples_pending != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [PERIOD_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [PERIOD_BITS-1:0] pick_period();
      case ($urandom_range(19))
         0:       return '0;
         1:       return PERIOD_BITS'(1);
         2:       return '1;
         3:       return PERIOD_BITS'($urandom);
         4, 5, 6: return PERIOD_BITS'($urandom_range(25, 300));
         default: return PERIOD_BITS'($urandom_range(1, 24));
      endcase
   endfunction

   task automatic run_phase(input bit pressure);
      logic [WAVE_BITS-1:0] code;
      int                   nticks;
      bit                   noisy;
      logic                 level;
      int                   run_left;
      wait_idle();
      code = ($urandom_range(9) < 8) ? WAVE_BITS'($urandom_range(4))
                                     : WAVE_BITS'($urandom_range(7, 5));
      if (pressure || $urandom_range(1)) begin
         write_reg(CSR_WAVEFORM, PERIOD_BITS'({$urandom(), code}));
      end
      if (pressure) begin
         write_reg(CSR_TRIGGER_ENABLE, '0);
         write_reg(CSR_PERIOD_TICKS, PERIOD_BITS'($urandom_range(2, 30)));
      end else begin
         if ($urandom_range(1)) begin
            write_reg(CSR_TRIGGER_ENABLE, PERIOD_BITS'($urandom));
         end
         if ($urandom_range(1)) begin
            write_reg(CSR_PERIOD_TICKS, pick_period());
         end
         if ($urandom_range(15) == 0) begin
            write_reg(CSR_UNUSED, PERIOD_BITS'($urandom));
         end
      end
      gaps_on = pressure ? 1'b0 : ($urandom_range(3) != 0);
      nticks  = pressure ? 48 : $urandom_range(8, 48);
      noisy   = ($urandom_range(7) == 0);
      level    = 1'($urandom_range(1));
      run_left = 0;
      if (pressure) begin
         hold_request = 1'b1;
      end
      repeat (nticks) begin
         if (noisy) begin
            level = 1'($urandom_range(1));
         end else if (run_left == 0) begin
            // trigger pulses: short low runs, then a high run
            level    = ~level;
            run_left = level ? $urandom_range(1, 6) : $urandom_range(1, 4);
         end
         run_left = (run_left > 0) ? run_left - 1 : 0;
         send_tick(level);
      end
   endtask

   initial begin
      int   random_base;
      logic levels [$];
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.trigger_level = 1'b0;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wr_data          = '0;
      drain_check          = 1'b0;
      hold_request         = 1'b0;
      gaps_on              = 1'b1;
      burst_left           = 0;
      ticks_sent           = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: triangle, free running, period 10000
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);

      // zero period acts as one and also cuts the running period short
      wait_idle();
      write_reg(CSR_WAVEFORM, PERIOD_BITS'({$urandom(), WAVE_SAWTOOTH}));
      write_reg(CSR_PERIOD_TICKS, '0);
      send_tick(1'b1);
      send_tick(1'b0);

      wait_idle();
      write_reg(CSR_WAVEFORM, PERIOD_BITS'({$urandom(), WAVE_SQUARE}));
      write_reg(CSR_PERIOD_TICKS, '1);
      send_tick(1'b0);
      send_tick(1'b1);
      wait_idle();
      write_reg(CSR_WAVEFORM, PERIOD_BITS'(WAVE_SINE));
      send_tick(1'b1);
      wait_idle();
      write_reg(CSR_WAVEFORM, PERIOD_BITS'(WAVE_CONSTANT));
      send_tick(1'b0);
      // undefined waveform code, upper data bits masked off
      wait_idle();
      write_reg(CSR_WAVEFORM, '1);
      send_tick(1'b1);

      // trigger mode: ends the running period, re-arm on low, start on high
      wait_idle();
      write_reg(CSR_WAVEFORM, PERIOD_BITS'(WAVE_TRIANGLE));
      write_reg(CSR_TRIGGER_ENABLE, PERIOD_BITS'(1));
      write_reg(CSR_PERIOD_TICKS, PERIOD_BITS'(3));
      levels = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      foreach (levels[i]) begin
         send_tick(levels[i]);
      end

      // write to an unused index leaves everything alone
      wait_idle();
      write_reg(CSR_UNUSED, PERIOD_BITS'($urandom));
      send_tick(1'b1);

      random_base = ticks_sent;
      run_phase(1'b1);
      while (ticks_sent - random_base < RANDOM_TICKS) begin
         run_phase(1'b0);
      end

      wait_idle();
      drain_check <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/twg_pkg.sv
rtl/twg_if.sv
rtl/twg_ctrl.sv
rtl/twg_dp.sv
rtl/triggered_waveform_generator.sv
tb/sv/twg_sample_checker.sv
tb/sv/tb_triggered_waveform_generator.sv
